// File: hdl/buddy_page_allocator_top_defines.svh
// ---------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Concurrent assertion shorthands used by the allocator top level.
// ---------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define BPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/bpa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Buddy page allocator package
// Request and result types, action and status codes.
// ---------------------------------------------------------------------------
package bpa_pkg;

    localparam int VALUE_W          = 15;
    localparam int RANK_IN_W        = 5;
    localparam int PAGE_IN_W        = 16;
    localparam int CFG_W            = 16;
    localparam int PAGE_COUNT_RESET = 32768;

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_QRANK  = 2'd2,
        ACT_QCOUNT = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOSPACE = 2'd2
    } status_t;

    typedef struct packed {
        logic alloc;
        logic frank;
        logic next;
    } mem_we_t;

    // first field in the highest bits
    typedef struct packed {
        logic [PAGE_IN_W-1:0]   page;
        logic [RANK_IN_W-1:0]   rank;
        action_t                action;
    } request_t;

    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        status_t              status;
    } result_t;

endpackage

// File: hdl/buddy_page_allocator_top.sv
`timescale 1ns / 1ps
// One item at a time through the sequencer and its single-port page store.
// Output register lets the next item start while a result waits.
// Reset and each page_count write: clear of all MAX_PAGES store entries, then the
// store is packed block by block, rank by rank; no items taken meanwhile.
// ---------------------------------------------------------------------------
// Buddy page allocator top level
// Stream ports, page count register and result output register.
// ---------------------------------------------------------------------------
`include "buddy_page_allocator_top_defines.svh"

module buddy_page_allocator_top #(
    parameter int MAX_RANK  = 16,
    parameter int MAX_PAGES = 32768
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // action[1:0], rank[6:2], page_index[22:7]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status[1:0], value[16:2]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int PCW      = $clog2(MAX_PAGES + 1);
    localparam int PC_RESET = (bpa_pkg::PAGE_COUNT_RESET > MAX_PAGES) ?
                              MAX_PAGES : bpa_pkg::PAGE_COUNT_RESET;

    logic [PCW-1:0]     pc_reg, pc_next;
    logic               m_tvalid_reg;
    bpa_pkg::result_t   m_res_reg;
    bpa_pkg::request_t  req;
    bpa_pkg::result_t   res;
    logic               req_ready, res_valid, res_free;

    assign cfg_ready = 1'b1;
    assign req       = bpa_pkg::request_t'(s_tdata[22:0]);
    assign s_tready  = req_ready && !cfg_valid;
    assign res_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'd0, m_res_reg};

    always_comb begin
        if (cfg_data == '0) begin
            pc_next = PCW'(1);
        end else if (32'(cfg_data) > MAX_PAGES) begin
            pc_next = PCW'(MAX_PAGES);
        end else begin
            pc_next = PCW'(cfg_data);
        end
    end

    bpa_core #(
        .MAX_RANK  (MAX_RANK),
        .MAX_PAGES (MAX_PAGES),
        .PCW       (PCW)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .restart    (cfg_valid),
        .page_count (pc_reg),
        .req_valid  (s_tvalid && !cfg_valid),
        .req        (req),
        .req_ready  (req_ready),
        .res_free   (res_free),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= PCW'(PC_RESET);
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                pc_reg <= pc_next;
            end
            if (res_valid) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    `BPA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `BPA_ASSERT_IMP(a_load_into_free, aclk, aresetn, res_valid, !m_tvalid_reg || m_tready)
    `BPA_ASSERT_IMP(a_error_zero, aclk, aresetn,
                    m_tvalid && m_res_reg.status != bpa_pkg::ST_OK, m_res_reg.value == '0)

endmodule

// File: hdl/bpa_page_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Buddy page allocator page store
// Single-port per-page store with field write enables and registered read.
// ---------------------------------------------------------------------------
module bpa_page_ram #(
    parameter int DEPTH = 32768,
    parameter int PW    = 15,
    parameter int RW    = 5
) (
    input  logic              aclk,
    input  logic [PW-1:0]     addr,
    input  bpa_pkg::mem_we_t  we,
    input  logic [RW-1:0]     wd_alloc,
    input  logic [RW-1:0]     wd_frank,
    input  logic [PW-1:0]     wd_next,
    output logic [RW-1:0]     rd_alloc,
    output logic [RW-1:0]     rd_frank,
    output logic [PW-1:0]     rd_next
);

    logic [RW-1:0] alloc_mem [0:DEPTH-1];
    logic [RW-1:0] frank_mem [0:DEPTH-1];
    logic [PW-1:0] next_mem  [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we.alloc) begin
            alloc_mem[addr] <= wd_alloc;
        end
        if (we.frank) begin
            frank_mem[addr] <= wd_frank;
        end
        if (we.next) begin
            next_mem[addr] <= wd_next;
        end
        rd_alloc <= alloc_mem[addr];
        rd_frank <= frank_mem[addr];
        rd_next  <= next_mem[addr];
    end

endmodule

// File: hdl/bpa_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Buddy page allocator sequencer
// Clears and packs the store, then runs allocate, free and queries step by step.
// ---------------------------------------------------------------------------
module bpa_core #(
    parameter int MAX_RANK  = 16,
    parameter int MAX_PAGES = 32768,
    parameter int PCW       = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               restart,
    input  logic [PCW-1:0]     page_count,
    input  logic               req_valid,
    input  bpa_pkg::request_t  req,
    output logic               req_ready,
    input  logic               res_free,
    output logic               res_valid,
    output bpa_pkg::result_t   res
);

    localparam int PW = $clog2(MAX_PAGES);
    localparam int RW = $clog2(MAX_RANK + 1);
    localparam int AW = ((PCW > MAX_RANK) ? PCW : MAX_RANK) + 1;
    localparam int VW = bpa_pkg::VALUE_W;

    typedef enum logic [17:0] {
        S_CLEAR    = 18'h00001,
        S_INIT     = 18'h00002,
        S_IDLE     = 18'h00004,
        S_EXEC     = 18'h00008,
        S_ALC_SCAN = 18'h00010,
        S_ALC_POP  = 18'h00020,
        S_ALC_SPL  = 18'h00040,
        S_FR_CHK   = 18'h00080,
        S_FR_LOOP  = 18'h00100,
        S_FR_BCHK  = 18'h00200,
        S_UL_RD    = 18'h00400,
        S_UL_CHK   = 18'h00800,
        S_UL_FIX   = 18'h01000,
        S_FR_PUSH  = 18'h02000,
        S_QR_CHK   = 18'h04000,
        S_QR_SCAN  = 18'h08000,
        S_QR_SCHK  = 18'h10000,
        S_RESP     = 18'h20000
    } state_t;

    function automatic logic [AW-1:0] blk_size(input logic [RW-1:0] r);
        blk_size = AW'(1) << (r - RW'(1));
    endfunction

    state_t state_reg, state_next;
    logic [PW-1:0]  clr_reg, clr_next;
    logic [AW-1:0]  pos_reg, pos_next;
    logic [RW-1:0]  r_reg, r_next;
    logic [RW-1:0]  tgt_reg, tgt_next;
    logic [PW-1:0]  start_reg, start_next;
    logic [PW-1:0]  buddy_reg, buddy_next;
    logic [PW-1:0]  ptr_reg, ptr_next;
    logic [PW-1:0]  prev_reg, prev_next;
    logic           has_prev_reg, has_prev_next;
    logic [PCW-1:0] idx_reg, idx_next;
    bpa_pkg::request_t req_reg, req_next;
    bpa_pkg::result_t  res_reg, res_next;

    logic [PW-1:0]  head_reg [0:MAX_RANK];
    logic [PCW-1:0] cnt_reg  [0:MAX_RANK];

    logic              hd_we;
    logic [RW-1:0]     hd_idx;
    logic [PW-1:0]     hd_val;
    logic              ct_inc, ct_dec;
    logic [RW-1:0]     ct_idx;
    logic              clr_tables;

    logic [PW-1:0]     mem_addr;
    bpa_pkg::mem_we_t  mem_we;
    logic [RW-1:0]     wd_alloc, wd_frank;
    logic [PW-1:0]     wd_next;
    logic [RW-1:0]     rd_alloc, rd_frank;
    logic [PW-1:0]     rd_next;

    logic [AW-1:0]     sz, tmp, page_ext;
    logic              page_ok, rank_ok;
    logic [RW-1:0]     rank_in;

    bpa_page_ram #(
        .DEPTH (MAX_PAGES),
        .PW    (PW),
        .RW    (RW)
    ) u_ram (
        .aclk     (aclk),
        .addr     (mem_addr),
        .we       (mem_we),
        .wd_alloc (wd_alloc),
        .wd_frank (wd_frank),
        .wd_next  (wd_next),
        .rd_alloc (rd_alloc),
        .rd_frank (rd_frank),
        .rd_next  (rd_next)
    );

    assign page_ext = AW'(req_reg.page);
    assign page_ok  = page_ext < AW'(page_count);
    assign rank_ok  = (req_reg.rank != '0) &&
                      (req_reg.rank <= bpa_pkg::RANK_IN_W'(MAX_RANK));
    assign rank_in  = RW'(req_reg.rank);
    assign req_ready = (state_reg == S_IDLE);
    assign res       = res_reg;

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        pos_next      = pos_reg;
        r_next        = r_reg;
        tgt_next      = tgt_reg;
        start_next    = start_reg;
        buddy_next    = buddy_reg;
        ptr_next      = ptr_reg;
        prev_next     = prev_reg;
        has_prev_next = has_prev_reg;
        idx_next      = idx_reg;
        req_next      = req_reg;
        res_next      = res_reg;
        hd_we         = 1'b0;
        hd_idx        = r_reg;
        hd_val        = start_reg;
        ct_inc        = 1'b0;
        ct_dec        = 1'b0;
        ct_idx        = r_reg;
        clr_tables    = 1'b0;
        mem_addr      = start_reg;
        mem_we        = '0;
        wd_alloc      = '0;
        wd_frank      = '0;
        wd_next       = '0;
        res_valid     = 1'b0;
        sz            = blk_size(r_reg);
        tmp           = '0;

        unique case (state_reg)
            S_CLEAR: begin
                mem_addr   = clr_reg;
                mem_we     = '1;
                clr_tables = 1'b1;
                if (clr_reg == PW'(MAX_PAGES - 1)) begin
                    pos_next   = '0;
                    r_next     = RW'(MAX_RANK);
                    state_next = S_INIT;
                end else begin
                    clr_next = clr_reg + PW'(1);
                end
            end
            S_INIT: begin
                if (((pos_reg & (sz - AW'(1))) == '0) &&
                    (AW'(page_count) - pos_reg >= sz)) begin
                    mem_addr     = pos_reg[PW-1:0];
                    mem_we.frank = 1'b1;
                    mem_we.next  = 1'b1;
                    wd_frank     = r_reg;
                    wd_next      = head_reg[r_reg];
                    hd_we        = 1'b1;
                    hd_val       = pos_reg[PW-1:0];
                    ct_inc       = 1'b1;
                    pos_next     = pos_reg + sz;
                end else if (r_reg == RW'(1)) begin
                    state_next = S_IDLE;
                end else begin
                    r_next = r_reg - RW'(1);
                end
            end
            S_IDLE: begin
                if (req_valid) begin
                    req_next   = req;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_next.status = bpa_pkg::ST_INVALID;
                res_next.value  = '0;
                mem_addr        = page_ext[PW-1:0];
                start_next      = page_ext[PW-1:0];
                state_next      = S_RESP;
                case (req_reg.action)
                    bpa_pkg::ACT_ALLOC: begin
                        if (rank_ok) begin
                            r_next     = rank_in;
                            tgt_next   = rank_in;
                            state_next = S_ALC_SCAN;
                        end
                    end
                    bpa_pkg::ACT_FREE: begin
                        if (page_ok) begin
                            state_next = S_FR_CHK;
                        end
                    end
                    bpa_pkg::ACT_QRANK: begin
                        if (page_ok) begin
                            state_next = S_QR_CHK;
                        end
                    end
                    default: begin
                        if (rank_ok) begin
                            res_next.status = bpa_pkg::ST_OK;
                            res_next.value  = VW'(cnt_reg[rank_in]);
                        end
                    end
                endcase
            end
            S_ALC_SCAN: begin
                if (cnt_reg[r_reg] != '0) begin
                    mem_addr   = head_reg[r_reg];
                    start_next = head_reg[r_reg];
                    state_next = S_ALC_POP;
                end else if (r_reg == RW'(MAX_RANK)) begin
                    res_next.status = bpa_pkg::ST_NOSPACE;
                    state_next      = S_RESP;
                end else begin
                    r_next = r_reg + RW'(1);
                end
            end
            S_ALC_POP: begin
                mem_we.frank = 1'b1;
                hd_we        = 1'b1;
                hd_val       = rd_next;
                ct_dec       = 1'b1;
                state_next   = S_ALC_SPL;
            end
            S_ALC_SPL: begin
                if (r_reg > tgt_reg) begin
                    r_next       = r_reg - RW'(1);
                    sz           = blk_size(r_reg - RW'(1));
                    tmp          = AW'(start_reg) + sz;
                    mem_addr     = tmp[PW-1:0];
                    mem_we.frank = 1'b1;
                    mem_we.next  = 1'b1;
                    wd_frank     = r_reg - RW'(1);
                    wd_next      = head_reg[r_reg - RW'(1)];
                    hd_we        = 1'b1;
                    hd_idx       = r_reg - RW'(1);
                    hd_val       = tmp[PW-1:0];
                    ct_inc       = 1'b1;
                    ct_idx       = r_reg - RW'(1);
                end else begin
                    mem_we.alloc    = 1'b1;
                    wd_alloc        = tgt_reg;
                    res_next.status = bpa_pkg::ST_OK;
                    res_next.value  = VW'(start_reg);
                    state_next      = S_RESP;
                end
            end
            S_FR_CHK: begin
                if (rd_alloc == '0) begin
                    state_next = S_RESP;
                end else begin
                    mem_we.alloc = 1'b1;
                    r_next       = rd_alloc;
                    state_next   = S_FR_LOOP;
                end
            end
            S_FR_LOOP: begin
                tmp = AW'(start_reg) ^ sz;
                if (r_reg >= RW'(MAX_RANK) || tmp >= AW'(page_count)) begin
                    state_next = S_FR_PUSH;
                end else begin
                    mem_addr   = tmp[PW-1:0];
                    buddy_next = tmp[PW-1:0];
                    state_next = S_FR_BCHK;
                end
            end
            S_FR_BCHK: begin
                if (rd_frank != r_reg) begin
                    state_next = S_FR_PUSH;
                end else begin
                    ptr_next      = head_reg[r_reg];
                    has_prev_next = 1'b0;
                    idx_next      = '0;
                    state_next    = S_UL_RD;
                end
            end
            S_UL_RD: begin
                mem_addr = ptr_reg;
                if (idx_reg >= cnt_reg[r_reg]) begin
                    state_next = S_FR_PUSH;
                end else begin
                    state_next = S_UL_CHK;
                end
            end
            S_UL_CHK: begin
                if (ptr_reg == buddy_reg) begin
                    if (has_prev_reg) begin
                        mem_addr    = prev_reg;
                        mem_we.next = 1'b1;
                        wd_next     = rd_next;
                    end else begin
                        hd_we  = 1'b1;
                        hd_val = rd_next;
                    end
                    state_next = S_UL_FIX;
                end else begin
                    prev_next     = ptr_reg;
                    has_prev_next = 1'b1;
                    ptr_next      = rd_next;
                    idx_next      = idx_reg + PCW'(1);
                    state_next    = S_UL_RD;
                end
            end
            S_UL_FIX: begin
                mem_addr     = buddy_reg;
                mem_we.frank = 1'b1;
                ct_dec       = 1'b1;
                if (buddy_reg < start_reg) begin
                    start_next = buddy_reg;
                end
                r_next     = r_reg + RW'(1);
                state_next = S_FR_LOOP;
            end
            S_FR_PUSH: begin
                mem_we.frank    = 1'b1;
                mem_we.next     = 1'b1;
                wd_frank        = r_reg;
                wd_next         = head_reg[r_reg];
                hd_we           = 1'b1;
                ct_inc          = 1'b1;
                res_next.status = bpa_pkg::ST_OK;
                state_next      = S_RESP;
            end
            S_QR_CHK: begin
                if (rd_alloc != '0) begin
                    res_next.status = bpa_pkg::ST_OK;
                    res_next.value  = VW'(rd_alloc);
                    state_next      = S_RESP;
                end else begin
                    r_next     = RW'(MAX_RANK);
                    state_next = S_QR_SCAN;
                end
            end
            S_QR_SCAN: begin
                tmp = page_ext & ~(sz - AW'(1));
                if (tmp < AW'(page_count)) begin
                    mem_addr   = tmp[PW-1:0];
                    state_next = S_QR_SCHK;
                end else if (r_reg == RW'(1)) begin
                    state_next = S_RESP;
                end else begin
                    r_next = r_reg - RW'(1);
                end
            end
            S_QR_SCHK: begin
                if (rd_frank == r_reg) begin
                    res_next.status = bpa_pkg::ST_OK;
                    res_next.value  = VW'(r_reg);
                    state_next      = S_RESP;
                end else if (r_reg == RW'(1)) begin
                    state_next = S_RESP;
                end else begin
                    r_next     = r_reg - RW'(1);
                    state_next = S_QR_SCAN;
                end
            end
            S_RESP: begin
                res_valid = res_free;
                if (res_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
        pos_reg      <= pos_next;
        r_reg        <= r_next;
        tgt_reg      <= tgt_next;
        start_reg    <= start_next;
        buddy_reg    <= buddy_next;
        ptr_reg      <= ptr_next;
        prev_reg     <= prev_next;
        has_prev_reg <= has_prev_next;
        idx_reg      <= idx_next;
        req_reg      <= req_next;
        res_reg      <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (clr_tables) begin
            for (int i = 0; i <= MAX_RANK; i++) begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end else begin
            if (hd_we) begin
                head_reg[hd_idx] <= hd_val;
            end
            if (ct_inc) begin
                cnt_reg[ct_idx] <= cnt_reg[ct_idx] + PCW'(1);
            end else if (ct_dec) begin
                cnt_reg[ct_idx] <= cnt_reg[ct_idx] - PCW'(1);
            end
        end
    end

endmodule
